// ===== rtl/core/sfl_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the slab free-list allocator
// no dependencies; every other file refers to this package by scoped names
package sfl_pkg;

    // fixed field widths
    localparam int HANDLE_W     = 6;
    localparam int HANDLE_DEPTH = 1 << HANDLE_W;
    localparam int STATUS_W     = 2;
    localparam int CFG_W        = 5;

    typedef logic [HANDLE_W-1:0] handle_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [CFG_W-1:0]    cfg_t;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_OOM     = 2'd1;
    localparam status_t ST_DOUBLE  = 2'd2;
    localparam status_t ST_FOREIGN = 2'd3;

    // objects per slab after reset
    localparam cfg_t CFG_RESET = 5'd16;

endpackage

// ===== rtl/core/sfl_req_if.sv =====
`timescale 1ns / 1ps
// request channel of the allocator: valid/ready plus operation and handle
// depends on sfl_pkg
interface sfl_req_if;
    logic             valid;
    logic             ready;
    logic             operation;
    sfl_pkg::handle_t handle_in;

    modport source (output valid, output operation, output handle_in, input ready);
    modport sink   (input valid, input operation, input handle_in, output ready);
endinterface

// ===== rtl/core/sfl_rsp_if.sv =====
`timescale 1ns / 1ps
// result channel of the allocator: valid/ready plus status and handle
// depends on sfl_pkg
interface sfl_rsp_if;
    logic             valid;
    logic             ready;
    sfl_pkg::status_t status;
    sfl_pkg::handle_t handle_out;

    modport source (output valid, output status, output handle_out, input ready);
    modport sink   (input valid, input status, input handle_out, output ready);
endinterface

// ===== rtl/core/sfl_front.sv =====
`timescale 1ns / 1ps
// front end: accepts requests, splits the handle into slab and slot, queues them
// depends on sfl_pkg and sfl_req_if
module sfl_front #(
    parameter int SLOTS = 16,
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    sfl_req_if.sink                    req,
    output logic                       cmd_valid,
    input  logic                       cmd_ready,
    output logic                       cmd_op,
    output sfl_pkg::handle_t           cmd_slab,
    output logic [SLOT_W-1:0]          cmd_slot
);

    localparam int QDEPTH = 2;

    // handle to slab / slot lookup, built at elaboration
    sfl_pkg::handle_t  slab_lut [sfl_pkg::HANDLE_DEPTH];
    logic [SLOT_W-1:0] slot_lut [sfl_pkg::HANDLE_DEPTH];

    genvar h;
    generate
        for (h = 0; h < sfl_pkg::HANDLE_DEPTH; h++)
        begin : g_lut
            assign slab_lut[h] = sfl_pkg::HANDLE_W'(h / SLOTS);
            assign slot_lut[h] = SLOT_W'(h % SLOTS);
        end
    endgenerate

    // two-entry request queue
    logic                 q_op_reg   [QDEPTH];
    sfl_pkg::handle_t     q_slab_reg [QDEPTH];
    logic [SLOT_W-1:0]    q_slot_reg [QDEPTH];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;
    logic                 push;
    logic                 pop;

    assign req.ready = (count_reg != 2'(QDEPTH));
    assign push      = req.valid && req.ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;

    assign cmd_op   = q_op_reg[rd_ptr_reg];
    assign cmd_slab = q_slab_reg[rd_ptr_reg];
    assign cmd_slot = q_slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue payload, decoded on the way in
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_op_reg[wr_ptr_reg]   <= req.operation;
            q_slab_reg[wr_ptr_reg] <= slab_lut[req.handle_in];
            q_slot_reg[wr_ptr_reg] <= slot_lut[req.handle_in];
        end
    end

endmodule

// ===== rtl/core/sfl_back.sv =====
`timescale 1ns / 1ps
// back end: sequencer that searches slabs, fills new stacks, pops, scans and pushes
// depends on sfl_pkg; holds the free-slot stack memory and the per-slab depths
module sfl_back #(
    parameter int MAX_SLABS = 4,
    parameter int SLOTS     = 16,
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CNT_W    = $clog2(SLOTS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CNT_W-1:0]      eff_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  logic                  cmd_op,
    input  sfl_pkg::handle_t      cmd_slab,
    input  logic [SLOT_W-1:0]     cmd_slot,
    output logic                  res_valid,
    input  logic                  res_ready,
    output sfl_pkg::status_t      res_status,
    output sfl_pkg::handle_t      res_handle
);

    localparam int SLAB_W    = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
    localparam int CRT_W     = $clog2(MAX_SLABS + 1);
    localparam int MEM_DEPTH = MAX_SLABS * SLOTS;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SEARCH   = 3'd1;
    localparam logic [2:0] S_FILL     = 3'd2;
    localparam logic [2:0] S_POP      = 3'd3;
    localparam logic [2:0] S_POP_WAIT = 3'd4;
    localparam logic [2:0] S_CHECK    = 3'd5;
    localparam logic [2:0] S_SCAN     = 3'd6;
    localparam logic [2:0] S_RESULT   = 3'd7;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [SLAB_W-1:0] s,
                                                  input logic [CNT_W-1:0] i);
        addr_of = ADDR_W'(ADDR_W'(s) * ADDR_W'(SLOTS) + ADDR_W'(i));
    endfunction

    logic [2:0]             state_reg, state_next;
    logic [SLAB_W-1:0]      slab_reg, slab_next;
    sfl_pkg::handle_t       hslab_reg, hslab_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [CRT_W-1:0]       created_reg, created_next;
    logic [CNT_W-1:0]       depth_reg [MAX_SLABS];
    logic [CNT_W-1:0]       depth_next [MAX_SLABS];
    sfl_pkg::status_t       status_reg, status_next;
    sfl_pkg::handle_t       handle_reg, handle_next;

    // free-slot stack memory, one region of SLOTS entries per slab
    logic [SLOT_W-1:0]      stack_mem [MEM_DEPTH];
    logic [SLOT_W-1:0]      rd_data_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [SLOT_W-1:0]      mem_wdata;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;

    logic [CNT_W-1:0]       cur_depth;
    logic                   match;

    assign cur_depth  = depth_reg[slab_reg];
    assign match      = cmp_valid_reg && (rd_data_reg == slot_reg);
    assign cmd_ready  = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_RESULT);
    assign res_status = status_reg;
    assign res_handle = handle_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        slab_next      = slab_reg;
        hslab_next     = hslab_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        cmp_valid_next = cmp_valid_reg;
        created_next   = created_reg;
        depth_next     = depth_reg;
        status_next    = status_reg;
        handle_next    = handle_reg;
        mem_we         = 1'b0;
        mem_waddr      = addr_of(slab_reg, idx_reg);
        mem_wdata      = SLOT_W'(idx_reg);
        mem_re         = 1'b0;
        mem_raddr      = addr_of(slab_reg, idx_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    hslab_next = cmd_slab;
                    slot_next  = cmd_slot;
                    if (cmd_op == sfl_pkg::OP_ALLOC)
                    begin
                        // start the search at the newest slab
                        slab_next  = (created_reg == '0) ? '0 : SLAB_W'(created_reg - 1'b1);
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end

            // one slab per cycle, newest to oldest
            S_SEARCH:
            begin
                if (created_reg != '0 && cur_depth != '0)
                begin
                    state_next = S_POP;
                end
                else if (created_reg != '0 && slab_reg != '0)
                begin
                    slab_next = slab_reg - 1'b1;
                end
                else if (32'(created_reg) >= MAX_SLABS)
                begin
                    status_next = sfl_pkg::ST_OOM;
                    handle_next = '0;
                    state_next  = S_RESULT;
                end
                else
                begin
                    slab_next  = SLAB_W'(created_reg);
                    idx_next   = '0;
                    state_next = S_FILL;
                end
            end

            // new slab: write slots 0..n-1 in order
            S_FILL:
            begin
                mem_we = 1'b1;
                if (idx_reg == eff_n - 1'b1)
                begin
                    depth_next[slab_reg] = eff_n;
                    created_next         = created_reg + 1'b1;
                    state_next           = S_POP;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // pop the top of the chosen stack
            S_POP:
            begin
                depth_next[slab_reg] = cur_depth - 1'b1;
                mem_re               = 1'b1;
                mem_raddr            = addr_of(slab_reg, cur_depth - 1'b1);
                state_next           = S_POP_WAIT;
            end

            S_POP_WAIT:
            begin
                status_next = sfl_pkg::ST_OK;
                handle_next = sfl_pkg::HANDLE_W'(sfl_pkg::HANDLE_W'(slab_reg)
                              * sfl_pkg::HANDLE_W'(SLOTS)
                              + sfl_pkg::HANDLE_W'(rd_data_reg));
                state_next  = S_RESULT;
            end

            // ownership check on free
            S_CHECK:
            begin
                if (32'(hslab_reg) >= 32'(created_reg) || 32'(slot_reg) >= 32'(eff_n))
                begin
                    status_next = sfl_pkg::ST_FOREIGN;
                    handle_next = '0;
                    state_next  = S_RESULT;
                end
                else
                begin
                    slab_next      = SLAB_W'(hslab_reg);
                    idx_next       = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = S_SCAN;
                end
            end

            // read one entry per cycle, compare the one read the cycle before
            S_SCAN:
            begin
                if (match)
                begin
                    cmp_valid_next = 1'b0;
                    status_next    = sfl_pkg::ST_DOUBLE;
                    handle_next    = '0;
                    state_next     = S_RESULT;
                end
                else if (idx_reg < cur_depth)
                begin
                    mem_re         = 1'b1;
                    idx_next       = idx_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                    handle_next    = '0;
                    state_next     = S_RESULT;
                    if (cur_depth >= eff_n)
                    begin
                        status_next = sfl_pkg::ST_DOUBLE;
                    end
                    else
                    begin
                        mem_we               = 1'b1;
                        mem_waddr            = addr_of(slab_reg, cur_depth);
                        mem_wdata            = slot_reg;
                        depth_next[slab_reg] = cur_depth + 1'b1;
                        status_next          = sfl_pkg::ST_OK;
                    end
                end
            end

            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmp_valid_reg <= 1'b0;
            created_reg   <= '0;
            for (int i = 0; i < MAX_SLABS; i++)
            begin
                depth_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            created_reg   <= created_next;
            depth_reg     <= depth_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        slab_reg   <= slab_next;
        hslab_reg  <= hslab_next;
        slot_reg   <= slot_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        handle_reg <= handle_next;
    end

    // stack memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

endmodule

// ===== rtl/core/slab_free_list_allocator_unit.sv =====
`timescale 1ns / 1ps
// slab free-list allocator top level: config register, output register, checks
// depends on sfl_pkg, sfl_req_if, sfl_rsp_if, sfl_front and sfl_back
//
// usage
//   req carries one request: operation 0 allocates a handle, 1 frees handle_in.
//   rsp returns one result per request, in order: status and handle_out
//   (handle is slab * SLOTS + slot on a good allocate, zero otherwise).
//   cfg_we / cfg_wdata write slots_in_use (objects per slab); write only while
//   no request is outstanding. 0 acts as 1, values above SLOTS act as SLOTS.
// operation
//   a two-entry queue takes requests while the sequencer works.
//   allocate: searches the slabs newest to oldest (up to MAX_SLABS), fills a
//   new slab stack with n entries if none has a free slot, then pops one.
//   free: checks ownership, then scans the slab's stack (up to n entries) and pushes.
//   one request is worked at a time; the stack walk sets the rate.
// reset
//   all slabs are released and slots_in_use returns to 16; the stack memory
//   needs no clearing pass.
// stalls
//   a finished result waits in the output register while rsp.ready is low;
//   the sequencer holds its next result until that register frees.
module slab_free_list_allocator_unit #(
    parameter int MAX_SLABS = 4,
    parameter int SLOTS     = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    sfl_req_if.sink           req,
    sfl_rsp_if.source         rsp,
    input  logic              cfg_we,
    input  sfl_pkg::cfg_t     cfg_wdata
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    sfl_pkg::cfg_t        cfg_reg, cfg_next;
    logic [CNT_W-1:0]     eff_n;

    logic                 cmd_valid;
    logic                 cmd_ready;
    logic                 cmd_op;
    sfl_pkg::handle_t     cmd_slab;
    logic [SLOT_W-1:0]    cmd_slot;

    logic                 res_valid;
    logic                 res_ready;
    sfl_pkg::status_t     res_status;
    sfl_pkg::handle_t     res_handle;

    logic                 out_valid_reg, out_valid_next;
    sfl_pkg::status_t     out_status_reg;
    sfl_pkg::handle_t     out_handle_reg;

    // configuration register and its clamped value
    assign cfg_next = cfg_we ? cfg_wdata : cfg_reg;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            eff_n = CNT_W'(1);
        end
        else if (32'(cfg_reg) > SLOTS)
        begin
            eff_n = CNT_W'(SLOTS);
        end
        else
        begin
            eff_n = CNT_W'(cfg_reg);
        end
    end

    // front end and sequencer
    sfl_front #(
        .SLOTS     (SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_op    (cmd_op),
        .cmd_slab  (cmd_slab),
        .cmd_slot  (cmd_slot)
    );

    sfl_back #(
        .MAX_SLABS  (MAX_SLABS),
        .SLOTS      (SLOTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .eff_n      (eff_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_op     (cmd_op),
        .cmd_slab   (cmd_slab),
        .cmd_slot   (cmd_slot),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_status (res_status),
        .res_handle (res_handle)
    );

    // output register
    assign res_ready      = !out_valid_reg || rsp.ready;
    assign out_valid_next = res_valid ? 1'b1 : (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= sfl_pkg::CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_status_reg <= res_status;
            out_handle_reg <= res_handle;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.handle_out = out_handle_reg;

    // checks
    a_handle_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != sfl_pkg::ST_OK) |-> rsp.handle_out == '0)
        else $error("nonzero handle on a failed request");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> rsp.valid)
        else $error("sequencer result not captured by output register");

    a_eff_n_range: assert property (@(posedge clk) disable iff (!rst_n)
        eff_n != '0 && 32'(eff_n) <= SLOTS)
        else $error("effective slot count out of range");

endmodule
